// ===== rtl/pssv_pkg.sv =====
package pssv_pkg;

    localparam logic [31:0] SNAP_MAGIC   = 32'h4650_4952;
    localparam logic [15:0] SNAP_VERSION = 16'd1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_HEADER = 3'd1;
    localparam logic [2:0] ST_COUNT      = 3'd2;
    localparam logic [2:0] ST_TRUNCATED  = 3'd3;
    localparam logic [2:0] ST_BAD_STATE  = 3'd4;
    localparam logic [2:0] ST_OWNERSHIP  = 3'd5;
    localparam logic [2:0] ST_TRAILING   = 3'd6;

    localparam logic KIND_FIELD  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [3:0] FLD_FLAGS         = 4'd0;
    localparam logic [3:0] FLD_OWNER         = 4'd1;
    localparam logic [3:0] FLD_NONNEG_FIRST  = 4'd11;
    localparam logic [5:0] REC_LAST_POS      = 6'd48;

    typedef struct packed {
        logic        kind;
        logic [11:0] record_index;
        logic [3:0]  field_index;
        logic [31:0] word_value;
        logic [2:0]  status;
        logic        last;
    } result_t;

    typedef struct packed {
        logic    first_valid;
        result_t first;
        logic    second_valid;
        result_t second;
    } push_t;

endpackage

// ===== rtl/pssv_if.sv =====
interface pssv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_blob;

    modport source (output valid, output data_byte, output end_of_blob, input ready);
    modport sink (input valid, input data_byte, input end_of_blob, output ready);
endinterface

interface pssv_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [11:0] record_index;
    logic [3:0]  field_index;
    logic [31:0] word_value;
    logic [2:0]  status;
    logic        last;

    modport source (
        output valid, output kind, output record_index, output field_index,
        output word_value, output status, output last, input ready
    );
    modport sink (
        input valid, input kind, input record_index, input field_index,
        input word_value, input status, input last, output ready
    );
endinterface

// ===== rtl/pssv_core.sv =====
module pssv_core
    import pssv_pkg::*;
#(
    parameter int MAX_RECORDS = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  logic [7:0]  data_byte,
    input  logic        end_of_blob,
    input  logic        cfg_write_en,
    input  logic [12:0] cfg_write_data,
    output push_t       push
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_RECORD = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;
    localparam logic [15:0] MAX_LIM  = 16'(MAX_RECORDS);

    logic [12:0] expected_count_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [5:0]  bp_reg, bp_next;
    logic [12:0] rc_reg, rc_next;
    logic [31:0] wa_reg, wa_next;
    logic [15:0] sc_reg, sc_next;
    logic [2:0]  err_reg, err_next;
    logic        grab_reg, grab_next;
    logic        ob_reg, ob_next;

    logic        fw_valid;
    result_t     fw;
    result_t     sw;

    function automatic logic [31:0] take_byte(
        input logic [31:0] w,
        input logic [7:0]  b,
        input logic [1:0]  k
    );
        logic [31:0] r;
        case (k)
            2'd0:    r = {24'b0, b};
            2'd1:    r = w | {16'b0, b, 8'b0};
            2'd2:    r = w | {8'b0, b, 16'b0};
            default: r = w | {b, 24'b0};
        endcase
        return r;
    endfunction

    always_comb
    begin
        logic [2:0] pos3;
        logic [1:0] kk;
        logic [5:0] pm1;
        logic [3:0] fld;
        logic       bad;
        logic [2:0] st;

        phase_next = phase_reg;
        bp_next    = bp_reg;
        rc_next    = rc_reg;
        wa_next    = wa_reg;
        sc_next    = sc_reg;
        err_next   = err_reg;
        grab_next  = grab_reg;
        ob_next    = ob_reg;
        fw_valid   = 1'b0;
        fw         = '0;
        fw.kind    = KIND_FIELD;
        fw.record_index = rc_reg[11:0];
        fw.last    = ~end_of_blob;
        pos3 = bp_reg[2:0];
        kk   = '0;
        pm1  = bp_reg - 6'd1;
        fld  = pm1[5:2] + 4'd1;
        bad  = 1'b0;
        st   = ST_OK;

        if (err_reg == ST_OK)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    kk = (pos3 < 3'd4) ? pos3[1:0] : {1'b0, pos3[0]};
                    wa_next = take_byte(wa_reg, data_byte, kk);
                    if (pos3 == 3'd3 && wa_next != SNAP_MAGIC)
                        err_next = ST_BAD_HEADER;
                    else if (pos3 == 3'd5 && wa_next[15:0] != SNAP_VERSION)
                        err_next = ST_BAD_HEADER;
                    if (pos3 == 3'd7)
                    begin
                        sc_next = wa_next[15:0];
                        bp_next = '0;
                        rc_next = '0;
                        if (wa_next[15:0] != {3'b0, expected_count_reg} ||
                            wa_next[15:0] > MAX_LIM)
                            err_next = ST_COUNT;
                        else
                            phase_next = (wa_next[15:0] == 16'd0) ? PH_DONE : PH_RECORD;
                    end
                    else
                    begin
                        bp_next = {3'b0, pos3} + 6'd1;
                    end
                end
                PH_RECORD:
                begin
                    if (bp_reg == 6'd0)
                    begin
                        if (|data_byte[7:2])
                        begin
                            err_next = ST_BAD_STATE;
                        end
                        else
                        begin
                            grab_next = data_byte[1];
                            fw_valid = 1'b1;
                            fw.field_index = FLD_FLAGS;
                            fw.word_value = {24'b0, data_byte};
                            bp_next = 6'd1;
                        end
                    end
                    else
                    begin
                        wa_next = take_byte(wa_reg, data_byte, pm1[1:0]);
                        if (pm1[1:0] == 2'd3)
                        begin
                            if (fld == FLD_OWNER)
                            begin
                                ob_next = grab_reg ? (wa_next == 32'd0) : (wa_next != 32'd0);
                                fw_valid = 1'b1;
                            end
                            else
                            begin
                                bad = &wa_next[30:23];
                                if (fld >= FLD_NONNEG_FIRST && wa_next[31] && |wa_next[30:0])
                                    bad = 1'b1;
                                if (bad)
                                    err_next = ST_BAD_STATE;
                                else
                                    fw_valid = 1'b1;
                            end
                            fw.field_index = fld;
                            fw.word_value = wa_next;
                        end
                        if (err_next == ST_OK)
                        begin
                            if (bp_reg >= REC_LAST_POS)
                            begin
                                if (ob_next)
                                begin
                                    err_next = ST_OWNERSHIP;
                                end
                                else
                                begin
                                    rc_next = rc_reg + 13'd1;
                                    bp_next = '0;
                                    if ({3'b0, rc_next} == sc_reg)
                                        phase_next = PH_DONE;
                                end
                            end
                            else
                            begin
                                bp_next = bp_reg + 6'd1;
                            end
                        end
                    end
                end
                default:
                begin
                    err_next = ST_TRAILING;
                end
            endcase
        end

        st = err_next;
        if (st == ST_OK)
        begin
            if (phase_next == PH_HEADER)
                st = ST_BAD_HEADER;
            else if (phase_next == PH_RECORD)
                st = (bp_next == 6'd0) ? ST_TRUNCATED : ST_BAD_STATE;
        end
        sw        = '0;
        sw.kind   = KIND_STATUS;
        sw.status = st;
        sw.last   = 1'b1;

        if (end_of_blob)
        begin
            phase_next = PH_HEADER;
            bp_next    = '0;
            rc_next    = '0;
            wa_next    = '0;
            sc_next    = '0;
            err_next   = ST_OK;
            grab_next  = 1'b0;
            ob_next    = 1'b0;
        end
    end

    assign push.first_valid  = fire & fw_valid;
    assign push.first        = fw;
    assign push.second_valid = fire & end_of_blob;
    assign push.second       = sw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_count_reg <= '0;
            phase_reg <= PH_HEADER;
            bp_reg    <= '0;
            rc_reg    <= '0;
            wa_reg    <= '0;
            sc_reg    <= '0;
            err_reg   <= ST_OK;
            grab_reg  <= 1'b0;
            ob_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                expected_count_reg <= cfg_write_data;
            if (fire)
            begin
                phase_reg <= phase_next;
                bp_reg    <= bp_next;
                rc_reg    <= rc_next;
                wa_reg    <= wa_next;
                sc_reg    <= sc_next;
                err_reg   <= err_next;
                grab_reg  <= grab_next;
                ob_reg    <= ob_next;
            end
        end
    end

endmodule

// ===== rtl/pssv_queue.sv =====
module pssv_queue
    import pssv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  push_t            push,
    output logic             space_ok,
    pssv_out_if.source       out_ch
);

    result_t    slot_reg [4];
    logic [2:0] count_reg, count_next;
    logic [1:0] head_reg, tail_reg;
    logic [1:0] tail_plus1;
    logic [1:0] n_push;
    logic       pop;
    result_t    first_item;
    result_t    head_item;

    assign n_push     = {1'b0, push.first_valid} + {1'b0, push.second_valid};
    assign first_item = push.first_valid ? push.first : push.second;
    assign tail_plus1 = tail_reg + 2'd1;
    assign pop        = out_ch.valid & out_ch.ready;
    assign count_next = count_reg + {1'b0, n_push} - {2'b0, pop};
    assign space_ok   = (count_reg <= 3'd2);

    assign head_item           = slot_reg[head_reg];
    assign out_ch.valid        = (count_reg != 3'd0);
    assign out_ch.kind         = head_item.kind;
    assign out_ch.record_index = head_item.record_index;
    assign out_ch.field_index  = head_item.field_index;
    assign out_ch.word_value   = head_item.word_value;
    assign out_ch.status       = head_item.status;
    assign out_ch.last         = head_item.last;

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            slot_reg[tail_reg] <= first_item;
        if (n_push == 2'd2)
            slot_reg[tail_plus1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            tail_reg  <= tail_reg + n_push;
            if (pop)
                head_reg <= head_reg + 2'd1;
        end
    end

endmodule

// ===== rtl/prop_snapshot_stream_validator.sv =====
// Validates a snapshot blob arriving one byte per beat on in_ch and emits each decoded
// field word, then a status beat on the final byte, on out_ch. Header and record checks
// are a byte counter, a word shift-in and a few compares that update state at the
// accepting edge. Each byte's results go into a four-entry queue at that edge and, if
// it was empty, the first is offered on out_ch in the next cycle. in_ch is ready
// whenever the queue has two free entries, so bytes flow at one per cycle while out_ch
// keeps up. The final byte of a blob may yield a field word plus a status beat; out_ch
// drains one result per cycle while ready. expected_count holds across blobs and must be
// written via cfg_write_en / cfg_write_data by the user only between blobs (unenforced).
module prop_snapshot_stream_validator
    import pssv_pkg::*;
#(
    parameter int MAX_RECORDS = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    pssv_in_if.sink     in_ch,
    pssv_out_if.source  out_ch,
    input  logic        cfg_write_en,
    input  logic [12:0] cfg_write_data
);

    logic  fire;
    logic  space_ok;
    push_t push;

    assign in_ch.ready = space_ok;
    assign fire        = in_ch.valid & space_ok;

    pssv_core #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .data_byte      (in_ch.data_byte),
        .end_of_blob    (in_ch.end_of_blob),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .push           (push)
    );

    pssv_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .space_ok (space_ok),
        .out_ch   (out_ch)
    );

`ifndef SYNTHESIS
    a_status_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.kind == KIND_STATUS |->
            out_ch.last && out_ch.record_index == 12'd0 &&
            out_ch.field_index == 4'd0 && out_ch.word_value == 32'd0)
        else $error("status beat carries field data");

    a_field_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.kind == KIND_FIELD |->
            out_ch.status == ST_OK && out_ch.field_index <= 4'd12)
        else $error("field beat malformed");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("input stalled with empty result queue");

    a_nonlast_then_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.ready && !out_ch.last |=>
            out_ch.valid && out_ch.kind == KIND_STATUS)
        else $error("non-last field beat not followed by status");
`endif

endmodule
